FILE: src/pol_pkg.sv
`timescale 1ns / 1ps

package pol_pkg;

   // field widths of the request and response items
   localparam int CMD_W    = 4;
   localparam int ITEM_W   = 32;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 5;
   // cell index width, wide enough for any legal position
   localparam int IDX_W    = POS_W;
   localparam int OP_W     = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INS_FRONT = 4'd0;
   localparam logic [CMD_W-1:0] CMD_INS_BACK  = 4'd1;
   localparam logic [CMD_W-1:0] CMD_INS_POS   = 4'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 4'd3;
   localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_DEL_POS   = 4'd5;
   localparam logic [CMD_W-1:0] CMD_DUMP      = 4'd6;
   localparam logic [CMD_W-1:0] CMD_COUNT     = 4'd7;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd8;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

   // cell chain operations
   localparam logic [OP_W-1:0] OP_NONE = 3'd0;
   localparam logic [OP_W-1:0] OP_INS  = 3'd1;
   localparam logic [OP_W-1:0] OP_DEL  = 3'd2;
   localparam logic [OP_W-1:0] OP_ROT  = 3'd3;
   localparam logic [OP_W-1:0] OP_CLR  = 3'd4;

   // controller to datapath command bundle
   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [IDX_W-1:0]    idx;
      logic                load;
      logic                take_item;
      logic [STATUS_W-1:0] status;
      logic                last;
   } dp_cmd_type;

endpackage

FILE: src/pol_dpath.sv
`timescale 1ns / 1ps

module pol_dpath #(
   parameter int CAPACITY = 16,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pol_pkg::dp_cmd_type                dp_cmd,
   input  logic signed [pol_pkg::ITEM_W-1:0]  req_value,
   output logic [CNT_W-1:0]                   count,
   output logic signed [pol_pkg::ITEM_W-1:0]  rsp_item_value,
   output logic [pol_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pol_pkg::LEN_W-1:0]          rsp_length,
   output logic                               rsp_last
);
   import pol_pkg::*;

   logic [ITEM_W-1:0]   cell_ff [CAPACITY];
   logic [ITEM_W-1:0]   cell_in [CAPACITY];
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [ITEM_W-1:0]   item_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [LEN_W-1:0]    length_ff;
   logic                last_ff;

   // cell chain: each cell picks from itself, a neighbor, the request value or the head cell
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ITEM_W-1:0] up_w;
      logic [ITEM_W-1:0] dn_w;
      logic              before_w;
      logic              at_w;
      logic              tail_w;

      if (g == CAPACITY - 1) begin : g_top
         assign up_w = cell_ff[g];
      end else begin : g_mid
         assign up_w = cell_ff[g+1];
      end
      if (g == 0) begin : g_head
         assign dn_w = req_value;
      end else begin : g_rest
         assign dn_w = cell_ff[g-1];
      end

      assign before_w = IDX_W'(g) < dp_cmd.idx;
      assign at_w     = IDX_W'(g) == dp_cmd.idx;
      assign tail_w   = CNT_W'(g + 1) == count_ff;

      always_comb begin
         case (dp_cmd.op)
            OP_INS:  cell_in[g] = before_w ? cell_ff[g] : (at_w ? req_value : dn_w);
            OP_DEL:  cell_in[g] = before_w ? cell_ff[g] : up_w;
            OP_ROT:  cell_in[g] = tail_w ? cell_ff[0] : up_w;
            default: cell_in[g] = cell_ff[g];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   // entry count
   always_comb begin
      case (dp_cmd.op)
         OP_INS:  count_in = count_ff + CNT_W'(1);
         OP_DEL:  count_in = count_ff - CNT_W'(1);
         OP_CLR:  count_in = '0;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         item_ff   <= dp_cmd.take_item ? cell_ff[0] : '0;
         status_ff <= dp_cmd.status;
         length_ff <= LEN_W'(count_in);
         last_ff   <= dp_cmd.last;
      end
   end

   assign count          = count_ff;
   assign rsp_item_value = item_ff;
   assign rsp_status     = status_ff;
   assign rsp_length     = length_ff;
   assign rsp_last       = last_ff;

   // count never passes capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // insert only with room, delete only with entries
   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.op == OP_INS |-> count_ff != CNT_W'(CAPACITY))
      else $error("insert into full list");

   a_del_some: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.op == OP_DEL |-> count_ff != '0)
      else $error("delete from empty list");

endmodule

FILE: src/pol_ctrl.sv
`timescale 1ns / 1ps

module pol_ctrl #(
   parameter int CAPACITY = 16,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pol_pkg::CMD_W-1:0]     req_cmd,
   input  logic [pol_pkg::POS_W-1:0]     req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [CNT_W-1:0]              count,
   output pol_pkg::dp_cmd_type           dp_cmd
);
   import pol_pkg::*;

   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DUMP = 1'b1;

   logic             state_ff;
   logic             state_in;
   logic [CNT_W-1:0] left_ff;
   logic [CNT_W-1:0] left_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             out_free;
   logic             accept;
   logic             full;
   logic             empty;
   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] cnt_x;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign full      = count == CNT_W'(CAPACITY);
   assign empty     = count == '0;
   assign pos_x     = CMP_W'(req_position);
   assign cnt_x     = CMP_W'(count);

   // command decode and dump sequencing
   always_comb begin
      dp_cmd   = '0;
      dp_cmd.op     = OP_NONE;
      dp_cmd.status = ST_OK;
      state_in = state_ff;
      left_in  = left_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               dp_cmd.load = 1'b1;
               dp_cmd.last = 1'b1;
               case (req_cmd)
                  CMD_INS_FRONT, CMD_INS_BACK: begin
                     if (full) begin
                        dp_cmd.status = ST_FULL;
                     end else begin
                        dp_cmd.op  = OP_INS;
                        dp_cmd.idx = (req_cmd == CMD_INS_FRONT) ? '0 : IDX_W'(count);
                     end
                  end
                  CMD_INS_POS: begin
                     if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
                        dp_cmd.status = ST_BADPOS;
                     end else if (full) begin
                        dp_cmd.status = ST_FULL;
                     end else begin
                        dp_cmd.op  = OP_INS;
                        dp_cmd.idx = IDX_W'(req_position - POS_W'(1));
                     end
                  end
                  CMD_DEL_FRONT, CMD_DEL_BACK: begin
                     if (empty) begin
                        dp_cmd.status = ST_EMPTY;
                     end else begin
                        dp_cmd.op  = OP_DEL;
                        dp_cmd.idx = (req_cmd == CMD_DEL_FRONT) ? '0 :
                                     IDX_W'(count - CNT_W'(1));
                     end
                  end
                  CMD_DEL_POS: begin
                     if (empty) begin
                        dp_cmd.status = ST_EMPTY;
                     end else if (pos_x == '0 || pos_x > cnt_x) begin
                        dp_cmd.status = ST_BADPOS;
                     end else begin
                        dp_cmd.op  = OP_DEL;
                        dp_cmd.idx = IDX_W'(req_position - POS_W'(1));
                     end
                  end
                  CMD_DUMP: begin
                     if (empty) begin
                        dp_cmd.status = ST_EMPTY;
                     end else begin
                        // head goes out now, chain rotates it to the tail
                        dp_cmd.take_item = 1'b1;
                        dp_cmd.op        = OP_ROT;
                        if (count != CNT_W'(1)) begin
                           dp_cmd.last = 1'b0;
                           left_in     = count - CNT_W'(1);
                           state_in    = S_DUMP;
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     dp_cmd.op = OP_CLR;
                  end
                  default: begin
                     dp_cmd.op = OP_NONE;
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               dp_cmd.load      = 1'b1;
               dp_cmd.take_item = 1'b1;
               dp_cmd.op        = OP_ROT;
               dp_cmd.last      = left_ff == CNT_W'(1);
               left_in          = left_ff - CNT_W'(1);
               if (left_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid flag
   assign rsp_valid_in = dp_cmd.load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a new response never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load |-> !(rsp_valid_ff && rsp_stall))
      else $error("response overwritten while stalled");

   // no request taken during a dump
   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |-> req_stall)
      else $error("request accepted during dump");

   // dump always has entries left to send
   a_dump_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |-> (left_ff != '0 && left_ff < count))
      else $error("dump counter out of range");

endmodule

FILE: src/positional_ordered_list.sv
`timescale 1ns / 1ps
// latency: a response is valid the cycle after its request transfer
// throughput, while rsp_stall is low: one edit, count or clear per cycle; a dump
//    holds requests until its last entry is loaded, one per cycle from the chain
// reset: list length and response valid clear; stored entries stay undefined
//    until written

module positional_ordered_list #(
   parameter int CAPACITY = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pol_pkg::CMD_W-1:0]         req_cmd,
   input  logic signed [pol_pkg::ITEM_W-1:0] req_value,
   input  logic [pol_pkg::POS_W-1:0]         req_position,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [pol_pkg::ITEM_W-1:0] rsp_item_value,
   output logic [pol_pkg::STATUS_W-1:0]      rsp_status,
   output logic [pol_pkg::LEN_W-1:0]         rsp_length,
   output logic                              rsp_last
);
   import pol_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   dp_cmd_type       dp_cmd;
   logic [CNT_W-1:0] count;

   // controller: decode, status checks, dump sequencing, handshakes
   pol_ctrl #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .count        (count),
      .dp_cmd       (dp_cmd)
   );

   // datapath: cell chain, entry count, response register
   pol_dpath #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .req_value      (req_value),
      .count          (count),
      .rsp_item_value (rsp_item_value),
      .rsp_status     (rsp_status),
      .rsp_length     (rsp_length),
      .rsp_last       (rsp_last)
   );

endmodule

FILE: test/pol_checker.sv
`timescale 1ns / 1ps

module pol_checker #(
   parameter int CAPACITY = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [pol_pkg::CMD_W-1:0]         req_cmd,
   input  logic signed [pol_pkg::ITEM_W-1:0] req_value,
   input  logic [pol_pkg::POS_W-1:0]         req_position,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [pol_pkg::ITEM_W-1:0] rsp_item_value,
   input  logic [pol_pkg::STATUS_W-1:0]      rsp_status,
   input  logic [pol_pkg::LEN_W-1:0]         rsp_length,
   input  logic                              rsp_last,
   output int                                mismatch_count,
   output int                                pending_count
);

   import pol_pkg::*;

   typedef struct packed {
      logic signed [ITEM_W-1:0] item_value;
      logic [STATUS_W-1:0]      status;
      logic [LEN_W-1:0]         length;
      logic                     last;
   } list_result_type;

   list_result_type          expected_results[$];
   logic signed [ITEM_W-1:0] list_cells[CAPACITY];
   int                       cell_count = 0;
   int                       error_total = 0;

   function automatic void push_result(input logic signed [ITEM_W-1:0] item,
                                       input logic [STATUS_W-1:0] status,
                                       input logic last);
      list_result_type r;
      r.item_value = item;
      r.status     = status;
      r.length     = LEN_W'(cell_count);
      r.last       = last;
      expected_results.push_back(r);
   endfunction

   // open a slot at idx by shifting the tail up
   function automatic void insert_cell(input int idx, input logic signed [ITEM_W-1:0] value);
      for (int i = cell_count; i > idx; i--)
         list_cells[i] = list_cells[i-1];
      list_cells[idx] = value;
      cell_count++;
   endfunction

   // close the slot at idx by shifting the tail down
   function automatic void remove_cell(input int idx);
      for (int i = idx; i < cell_count - 1; i++)
         list_cells[i] = list_cells[i+1];
      cell_count--;
   endfunction

   // apply one command to the shadow list and queue its results
   function automatic void predict_list_command(input logic [CMD_W-1:0] cmd,
                                                input logic signed [ITEM_W-1:0] value,
                                                input logic [POS_W-1:0] position);
      logic [STATUS_W-1:0] status;
      int                  pos;
      status = ST_OK;
      pos    = int'(position);
      case (cmd)
         CMD_INS_FRONT, CMD_INS_BACK: begin
            if (cell_count >= CAPACITY)
               status = ST_FULL;
            else
               insert_cell((cmd == CMD_INS_FRONT) ? 0 : cell_count, value);
         end
         CMD_INS_POS: begin
            // position check wins over the full check
            if (pos == 0 || pos > cell_count + 1)
               status = ST_BADPOS;
            else if (cell_count >= CAPACITY)
               status = ST_FULL;
            else
               insert_cell(pos - 1, value);
         end
         CMD_DEL_FRONT, CMD_DEL_BACK: begin
            if (cell_count == 0)
               status = ST_EMPTY;
            else
               remove_cell((cmd == CMD_DEL_FRONT) ? 0 : cell_count - 1);
         end
         CMD_DEL_POS: begin
            if (cell_count == 0)
               status = ST_EMPTY;
            else if (pos == 0 || pos > cell_count)
               status = ST_BADPOS;
            else
               remove_cell(pos - 1);
         end
         CMD_DUMP: begin
            if (cell_count == 0) begin
               push_result('0, ST_EMPTY, 1'b1);
            end else begin
               for (int i = 0; i < cell_count; i++)
                  push_result(list_cells[i], ST_OK, (i == cell_count - 1));
            end
            return;
         end
         CMD_CLEAR: begin
            cell_count = 0;
         end
         default: begin
         end
      endcase
      push_result('0, status, 1'b1);
   endfunction

   // compare response transfers, then predict from request transfers
   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         cell_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response transfer: item_value %0d status %0d length %0d",
                      rsp_item_value, rsp_status, rsp_length);
               error_total++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_item_value !== want.item_value) begin
                  $error("rsp_item_value mismatch: expected %0d, actual %0d",
                         want.item_value, rsp_item_value);
                  error_total++;
               end
               if (rsp_status !== want.status) begin
                  $error("rsp_status mismatch: expected %0d, actual %0d",
                         want.status, rsp_status);
                  error_total++;
               end
               if (rsp_length !== want.length) begin
                  $error("rsp_length mismatch: expected %0d, actual %0d",
                         want.length, rsp_length);
                  error_total++;
               end
               if (rsp_last !== want.last) begin
                  $error("rsp_last mismatch: expected %0d, actual %0d", want.last, rsp_last);
                  error_total++;
               end
            end
         end
         if (req_valid && !req_stall)
            predict_list_command(req_cmd, req_value, req_position);
      end
      pending_count  <= expected_results.size();
      mismatch_count <= error_total;
   end

endmodule

FILE: test/tb_positional_ordered_list.sv
`timescale 1ns / 1ps

module tb_positional_ordered_list;

   import pol_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int RANDOM_CMDS = 185;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 8;

   // codes the block must ignore
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_cmd = '0;
   logic signed [ITEM_W-1:0] req_value = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [ITEM_W-1:0] rsp_item_value;
   logic [STATUS_W-1:0]      rsp_status;
   logic [LEN_W-1:0]         rsp_length;
   logic                     rsp_last;

   int mismatch_count;
   int pending_count;
   int cycle_count = 0;
   int burst_left = 0;
   int planned_len = 0;
   int random_sent = 0;
   int stall_mode = 0;
   int stall_left = 0;

   always #4 clock = ~clock;

   positional_ordered_list #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item_value(rsp_item_value),
      .rsp_status(rsp_status),
      .rsp_length(rsp_length),
      .rsp_last(rsp_last)
   );

   pol_checker #(
      .CAPACITY(CAPACITY)
   ) list_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item_value(rsp_item_value),
      .rsp_status(rsp_status),
      .rsp_length(rsp_length),
      .rsp_last(rsp_last),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count)
   );

   // receiver stall pattern: modes from never to almost always stalled
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(10, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 6);
         default: rsp_stall <= ($urandom_range(0, 15) != 0);
      endcase
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic signed [ITEM_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // one request transfer, with bursts and random gaps between them
   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic signed [ITEM_W-1:0] value,
                           input logic [POS_W-1:0] position);
      int gap;
      int pos;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_value    <= value;
      req_position <= position;
      do @(posedge clock); while (req_stall);
      // rough length tracking to aim positions at the live range
      pos = int'(position);
      case (cmd)
         CMD_INS_FRONT, CMD_INS_BACK: if (planned_len < CAPACITY) planned_len++;
         CMD_INS_POS:
            if (pos >= 1 && pos <= planned_len + 1 && planned_len < CAPACITY) planned_len++;
         CMD_DEL_FRONT, CMD_DEL_BACK: if (planned_len > 0) planned_len--;
         CMD_DEL_POS: if (planned_len > 0 && pos >= 1 && pos <= planned_len) planned_len--;
         CMD_CLEAR: planned_len = 0;
         default: begin
         end
      endcase
   endtask

   // hold off the sender until every expected result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic logic [POS_W-1:0] pick_position(input int span);
      if ($urandom_range(0, 4) == 0)
         return POS_W'($urandom_range(0, 255));
      return POS_W'($urandom_range(1, span));
   endfunction

   task automatic random_edit();
      logic [CMD_W-1:0] cmd;
      cmd = CMD_W'($urandom_range(CMD_INS_FRONT, CMD_COUNT));
      if (cmd == CMD_DEL_POS)
         send_cmd(cmd, random_value(), pick_position((planned_len > 0) ? planned_len : 1));
      else
         send_cmd(cmd, random_value(), pick_position(planned_len + 1));
      random_sent++;
   endtask

   task automatic random_insert();
      case ($urandom_range(0, 2))
         0: send_cmd(CMD_INS_FRONT, random_value(), POS_W'($urandom_range(0, 255)));
         1: send_cmd(CMD_INS_BACK, random_value(), POS_W'($urandom_range(0, 255)));
         default: send_cmd(CMD_INS_POS, random_value(),
                           POS_W'($urandom_range(1, planned_len + 1)));
      endcase
      random_sent++;
   endtask

   // fill to capacity, then push against the full list
   task automatic fill_sequence();
      while (planned_len < CAPACITY)
         random_insert();
      send_cmd(CMD_INS_POS, random_value(), POS_W'(CAPACITY + 1));
      send_cmd(CMD_INS_POS, random_value(), POS_W'(CAPACITY + 2));
      random_insert();
      send_cmd(CMD_DUMP, '0, '0);
      random_sent += 3;
   endtask

   // empty the list with mixed deletes, then delete once more
   task automatic drain_sequence();
      while (planned_len > 0) begin
         case ($urandom_range(0, 2))
            0: send_cmd(CMD_DEL_FRONT, random_value(), '0);
            1: send_cmd(CMD_DEL_BACK, random_value(), '0);
            default: send_cmd(CMD_DEL_POS, random_value(),
                              POS_W'($urandom_range(1, planned_len)));
         endcase
         random_sent++;
      end
      send_cmd(CMD_W'($urandom_range(CMD_DEL_FRONT, CMD_DEL_POS)), random_value(),
               POS_W'($urandom_range(0, 255)));
      random_sent++;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, bad positions, value extremes, ignored codes
      send_cmd(CMD_DUMP, '0, '0);
      send_cmd(CMD_DEL_FRONT, '0, '0);
      send_cmd(CMD_DEL_BACK, '0, '0);
      send_cmd(CMD_DEL_POS, '0, 8'd1);
      send_cmd(CMD_DEL_POS, '0, 8'd0);
      send_cmd(CMD_COUNT, '0, '0);
      send_cmd(CMD_INS_POS, 32'sd5, 8'd0);
      send_cmd(CMD_INS_POS, 32'sd6, 8'd2);
      send_cmd(CMD_INS_FRONT, 32'sh8000_0000, 8'd0);
      send_cmd(CMD_INS_BACK, 32'sh7fff_ffff, 8'd255);
      send_cmd(CMD_INS_POS, -32'sd1, 8'd2);
      send_cmd(CMD_INS_POS, 32'sd0, 8'd5);
      send_cmd(CMD_INS_POS, 32'sh5a5a_a5a5, 8'd4);
      send_cmd(CMD_DEL_POS, '0, 8'd0);
      send_cmd(CMD_DEL_POS, '0, 8'd5);
      send_cmd(CMD_DEL_POS, '0, 8'd255);
      send_cmd(CMD_DUMP, '0, '0);
      send_cmd(CMD_DEL_POS, '0, 8'd2);
      send_cmd(CMD_DEL_FRONT, '0, '0);
      send_cmd(CMD_UNUSED_LO, -32'sd1, 8'd255);
      send_cmd(CMD_UNUSED_HI, -32'sd1, 8'd255);
      send_cmd(CMD_DEL_BACK, '0, '0);
      send_cmd(CMD_INS_BACK, 32'sd42, '0);
      send_cmd(CMD_CLEAR, '0, '0);
      send_cmd(CMD_DUMP, '0, '0);
      wait_drained();

      // random: well-formed fill, edit and drain runs with some noise
      fill_sequence();
      while (random_sent < RANDOM_CMDS) begin
         case ($urandom_range(0, 9))
            0, 1: fill_sequence();
            2, 3: drain_sequence();
            4, 5, 6: begin
               repeat ($urandom_range(3, 10)) random_edit();
            end
            7: begin
               send_cmd(CMD_DUMP, random_value(), POS_W'($urandom_range(0, 255)));
               send_cmd(CMD_COUNT, random_value(), POS_W'($urandom_range(0, 255)));
               random_sent += 2;
            end
            8: begin
               repeat ($urandom_range(1, 4)) begin
                  send_cmd(CMD_W'($urandom_range(0, 15)), random_value(),
                           POS_W'($urandom_range(0, 255)));
                  random_sent++;
               end
            end
            default: begin
               send_cmd(CMD_CLEAR, random_value(), POS_W'($urandom_range(0, 255)));
               send_cmd(CMD_DUMP, random_value(), POS_W'($urandom_range(0, 255)));
               random_sent += 2;
               wait_drained();
            end
         endcase
      end

      // wind down and give the verdict
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
